// ----- sv/tolu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermal operating point limiter package
// Shared constants, operating point ROMs, whitelist levels and the
// controller/datapath command and status types.
// ----------------------------------------------------------------------------
package tolu_pkg;

  localparam int TableEntries    = 35;
  localparam int WhitelistLevels = 7;

  localparam int StW    = 6;
  localparam int FreqW  = 21;
  localparam int TimeW  = 48;
  localparam int PerfW  = 16;
  localparam int CoreW  = 3;
  localparam int LvlW   = 8;
  localparam int DurW   = 21;
  localparam int ProdW  = 31;
  localparam int MsPerSec = 1000;

  localparam logic [StW-1:0] TopState = StW'(TableEntries - 1);

  localparam logic [1:0] OpCool     = 2'd0;
  localparam logic [1:0] OpLevel    = 2'd1;
  localparam logic [1:0] OpDuration = 2'd2;

  localparam logic [1:0] CfgPowerMode = 2'd0;
  localparam logic [1:0] CfgIntBus    = 2'd1;
  localparam logic [1:0] CfgDisplay   = 2'd2;
  localparam logic [1:0] CfgCamera    = 2'd3;

  localparam logic [1:0] ModeBench = 2'd3;

  localparam logic [FreqW-1:0] IntBusRst  = 21'd543000;
  localparam logic [FreqW-1:0] DisplayRst = 21'd317000;
  localparam logic [FreqW-1:0] CameraRst  = 21'd777000;

  typedef struct packed {
    logic [CoreW-1:0] lit_n;
    logic [CoreW-1:0] big_n;
    logic [FreqW-1:0] big_f;
    logic [FreqW-1:0] lit_f;
    logic [FreqW-1:0] gpu_f;
    logic [FreqW-1:0] mem_f;
    logic [PerfW-1:0] perf;
  } opp_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic eval;
    logic scan;
    logic mul;
    logic add;
    logic upd;
    logic emit;
  } tolu_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       bench;
    logic       same_state;
    logic       scan_last;
    logic       out_free;
  } tolu_sts_t;

  function automatic opp_t mk(int ln, int bn, int bf, int lf, int gf, int mf, int pf);
    opp_t r;
    r.lit_n = CoreW'(ln);
    r.big_n = CoreW'(bn);
    r.big_f = FreqW'(bf);
    r.lit_f = FreqW'(lf);
    r.gpu_f = FreqW'(gf);
    r.mem_f = FreqW'(mf);
    r.perf  = PerfW'(pf);
    return r;
  endfunction

  function automatic opp_t normal_opp(logic [StW-1:0] idx);
    opp_t r;
    case (idx)
      0:  r = mk(4,4,2000000,1500000,600,825000,37110);
      1:  r = mk(4,3,2000000,1500000,600,825000,31110);
      2:  r = mk(4,4,1800000,1500000,600,825000,36360);
      3:  r = mk(4,3,1800000,1500000,600,825000,30060);
      4:  r = mk(4,2,2000000,1500000,600,825000,24670);
      5:  r = mk(4,4,1600000,1500000,600,825000,33560);
      6:  r = mk(4,2,1800000,1500000,600,825000,23760);
      7:  r = mk(4,3,1600000,1500000,600,825000,27960);
      8:  r = mk(4,1,2000000,1500000,600,825000,18160);
      9:  r = mk(4,4,1400000,1500000,600,825000,30760);
      10: r = mk(4,2,1600000,1500000,600,825000,22360);
      11: r = mk(4,3,1400000,1500000,600,825000,25860);
      12: r = mk(4,4,1200000,1500000,600,825000,27960);
      13: r = mk(4,1,1800000,1500000,600,825000,17460);
      14: r = mk(4,2,1400000,1500000,600,825000,20960);
      15: r = mk(4,3,1200000,1500000,600,825000,23760);
      16: r = mk(4,1,1600000,1500000,600,825000,16760);
      17: r = mk(4,4,1000000,1500000,550,825000,25160);
      18: r = mk(4,2,1200000,1500000,550,825000,19560);
      19: r = mk(4,3,1000000,1500000,550,825000,21660);
      20: r = mk(4,1,1400000,1500000,550,825000,16760);
      21: r = mk(4,2,1000000,1500000,550,825000,18160);
      22: r = mk(4,1,1200000,1500000,500,825000,15360);
      23: r = mk(4,1,1000000,1500000,500,825000,14660);
      24: r = mk(4,1,1000000,1400000,500,825000,14650);
      25: r = mk(4,1,1000000,1200000,500,825000,14645);
      26: r = mk(3,1,1000000,1400000,500,825000,14644);
      27: r = mk(4,1,1000000,1000000,500,825000,14642);
      28: r = mk(3,1,1000000,1200000,500,825000,14641);
      29: r = mk(3,1,1000000,1000000,500,825000,14640);
      30: r = mk(4,0,2000000,1500000,500,633000,11160);
      31: r = mk(4,0,2000000,1500000,420,543000,10460);
      32: r = mk(4,0,2000000,1400000,420,543000,9672);
      33: r = mk(4,0,2000000,1400000,420,543000,7812);
      34: r = mk(4,0,2000000,1400000,420,543000,7811);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic opp_t bench_opp(logic [StW-1:0] idx);
    opp_t r;
    case (idx)
      0:  r = mk(4,4,2000000,1500000,600,825000,37110);
      1:  r = mk(4,4,1900000,1500000,600,825000,36360);
      2:  r = mk(4,4,1800000,1500000,600,825000,33560);
      3:  r = mk(4,4,1700000,1500000,600,825000,33560);
      4:  r = mk(4,4,1600000,1500000,600,825000,33560);
      5:  r = mk(4,4,1500000,1500000,600,825000,33560);
      6:  r = mk(4,4,1400000,1500000,600,825000,33560);
      7:  r = mk(4,4,1300000,1500000,600,825000,33560);
      8:  r = mk(4,3,2000000,1500000,600,825000,27960);
      9:  r = mk(4,3,1900000,1500000,600,825000,27960);
      10: r = mk(4,3,1800000,1500000,600,825000,27960);
      11: r = mk(4,3,1700000,1500000,600,825000,27960);
      12: r = mk(4,3,1600000,1500000,600,825000,27960);
      13: r = mk(4,3,1500000,1500000,600,825000,27960);
      14: r = mk(4,3,1400000,1500000,600,825000,27960);
      15: r = mk(4,3,1300000,1500000,600,825000,27960);
      16: r = mk(4,2,2000000,1500000,600,825000,27960);
      17: r = mk(4,2,1900000,1500000,600,825000,27960);
      18: r = mk(4,2,1800000,1500000,600,825000,27960);
      19: r = mk(4,2,1700000,1500000,600,825000,27960);
      20: r = mk(4,2,1600000,1500000,600,825000,27960);
      21: r = mk(4,2,1500000,1500000,600,825000,27960);
      22: r = mk(4,2,1400000,1500000,600,825000,27960);
      23: r = mk(4,2,1300000,1500000,600,825000,27960);
      24: r = mk(4,2,1200000,1500000,600,825000,27960);
      25: r = mk(4,2,1100000,1500000,600,825000,27960);
      26: r = mk(4,1,1800000,1500000,600,825000,27960);
      27: r = mk(4,1,1700000,1500000,600,825000,27960);
      28: r = mk(4,1,1600000,1500000,600,825000,27960);
      29: r = mk(4,1,1500000,1500000,600,825000,27960);
      30: r = mk(4,1,1400000,1500000,600,825000,27960);
      31: r = mk(4,1,1200000,1500000,600,825000,27960);
      32: r = mk(4,1,1000000,1500000,600,825000,27960);
      33: r = mk(4,1,800000,1500000,600,825000,27960);
      34: r = mk(4,0,2000000,1500000,600,825000,27960);
      default: r = '0;
    endcase
    return r;
  endfunction

  // level 0 means no cap; values saturate to the top state
  function automatic logic [StW-1:0] level_value(logic [3:0] lvl);
    logic [StW-1:0] v;
    case (lvl)
      0: v = TopState;
      1: v = 6'd30;
      2: v = 6'd25;
      3: v = 6'd21;
      4: v = 6'd15;
      5: v = 6'd9;
      default: v = 6'd0;
    endcase
    return (v > TopState) ? TopState : v;
  endfunction

endpackage

// ----- sv/tolu_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limiter controller
// Sequences decode, state evaluation, table scan, deadline update and
// result emission; drives datapath commands.
// ----------------------------------------------------------------------------
module tolu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tolu_pkg::tolu_sts_t sts_i,
  output tolu_pkg::tolu_cmd_t cmd_o
);
  import tolu_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StDecode = 3'd1;
  localparam logic [2:0] StEval   = 3'd2;
  localparam logic [2:0] StScan   = 3'd3;
  localparam logic [2:0] StMul    = 3'd4;
  localparam logic [2:0] StAdd    = 3'd5;
  localparam logic [2:0] StUpd    = 3'd6;
  localparam logic [2:0] StEmit   = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDecode;
        end
      end
      StDecode: begin
        cmd_o.decode = 1'b1;
        unique case (sts_i.op)
          OpCool:     state_d = StEval;
          OpLevel:    state_d = StEmit;
          OpDuration: state_d = StMul;
          default:    state_d = StIdle;
        endcase
      end
      StEval: begin
        cmd_o.eval = 1'b1;
        if (sts_i.same_state) begin
          state_d = StIdle;
        end else if (sts_i.bench) begin
          state_d = StEmit;
        end else begin
          state_d = StScan;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = StEmit;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StAdd;
      end
      StAdd: begin
        cmd_o.add = 1'b1;
        state_d   = StUpd;
      end
      StUpd: begin
        cmd_o.upd = 1'b1;
        state_d   = StEmit;
      end
      StEmit: begin
        // hold until the result register can take the beat
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/tolu_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limiter datapath
// Input and config registers, limit state, table scan unit, deadline
// arithmetic and the result register.
// ----------------------------------------------------------------------------
module tolu_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tolu_pkg::tolu_cmd_t           cmd_i,
  output tolu_pkg::tolu_sts_t           sts_o,
  input  logic [1:0]                    op_i,
  input  logic [tolu_pkg::StW-1:0]      cooling_state_i,
  input  logic [tolu_pkg::LvlW-1:0]     whitelist_level_i,
  input  logic [tolu_pkg::DurW-1:0]     duration_s_i,
  input  logic [tolu_pkg::TimeW-1:0]    now_ms_i,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [tolu_pkg::FreqW-1:0]    cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          kind_o,
  output logic                          status_o,
  output logic [tolu_pkg::StW-1:0]      entry_index_o,
  output logic [tolu_pkg::FreqW-1:0]    big_khz_o,
  output logic [tolu_pkg::FreqW-1:0]    little_khz_o,
  output logic [tolu_pkg::FreqW-1:0]    gpu_khz_o,
  output logic [tolu_pkg::FreqW-1:0]    mem_freq_o,
  output logic [tolu_pkg::FreqW-1:0]    int_freq_out_o,
  output logic [tolu_pkg::FreqW-1:0]    disp_freq_out_o,
  output logic [tolu_pkg::FreqW-1:0]    cam_freq_out_o,
  output logic [tolu_pkg::CoreW-1:0]    little_cores_o,
  output logic [tolu_pkg::CoreW-1:0]    big_cores_o
);
  import tolu_pkg::*;

  // captured item
  logic [1:0]       op_q;
  logic [StW-1:0]   cs_q;
  logic [LvlW-1:0]  wl_q;
  logic [DurW-1:0]  dur_q;
  logic [TimeW-1:0] now_q;

  // configuration
  logic [1:0]       power_mode_q;
  logic [FreqW-1:0] int_bus_q, disp_q, cam_q;

  // limiter state
  logic [StW-1:0]   level_limit_q;
  logic [TimeW-1:0] limit_end_q;
  logic [StW-1:0]   last_state_q;
  logic             last_valid_q;

  // work registers
  logic [StW-1:0]   idx_q, pick_q;
  logic [PerfW-1:0] best_q;
  logic [ProdW-1:0] prod_q;
  logic [TimeW:0]   sum_q;
  logic             bad_q;

  logic             out_valid_q;
  logic             out_free;

  logic [StW-1:0]   s_sat, s_cap;
  logic             hit, expired, same;
  opp_t             scan_opp, pick_opp;
  logic [TimeW-1:0] end_sat;

  assign s_sat   = (cs_q > TopState) ? TopState : cs_q;
  assign hit     = (s_sat >= level_limit_q);
  assign expired = (now_q >= limit_end_q);
  assign s_cap   = (hit && !expired) ? level_limit_q : s_sat;
  assign same    = last_valid_q && (s_cap == last_state_q);

  assign scan_opp = normal_opp(idx_q);
  assign pick_opp = (power_mode_q == ModeBench) ? bench_opp(pick_q) : normal_opp(pick_q);
  assign end_sat  = sum_q[TimeW] ? {TimeW{1'b1}} : sum_q[TimeW-1:0];

  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.op         = op_q;
  assign sts_o.bench      = (power_mode_q == ModeBench);
  assign sts_o.same_state = same;
  assign sts_o.scan_last  = (idx_q == TopState);
  assign sts_o.out_free   = out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      cs_q  <= cooling_state_i;
      wl_q  <= whitelist_level_i;
      dur_q <= duration_s_i;
      now_q <= now_ms_i;
    end
    if (cmd_i.eval) begin
      idx_q  <= s_cap;
      pick_q <= s_cap;
      best_q <= '0;   // strict compare keeps the start entry on ties
    end
    if (cmd_i.scan) begin
      if (scan_opp.perf > best_q) begin
        best_q <= scan_opp.perf;
        pick_q <= idx_q;
      end
      if (idx_q != TopState) begin
        idx_q <= idx_q + 1'b1;
      end
    end
    if (cmd_i.mul) begin
      prod_q <= ProdW'(dur_q) * ProdW'(MsPerSec);
    end
    if (cmd_i.add) begin
      sum_q <= {1'b0, now_q} + (TimeW + 1)'(prod_q);
    end
    if (cmd_i.load) begin
      bad_q <= 1'b0;
    end else if (cmd_i.decode && op_q == OpLevel) begin
      bad_q <= !(wl_q < LvlW'(WhitelistLevels));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_mode_q <= '0;
      int_bus_q    <= IntBusRst;
      disp_q       <= DisplayRst;
      cam_q        <= CameraRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgPowerMode: power_mode_q <= cfg_data_i[1:0];
        CfgIntBus:    int_bus_q    <= cfg_data_i;
        CfgDisplay:   disp_q       <= cfg_data_i;
        CfgCamera:    cam_q        <= cfg_data_i;
        default:      power_mode_q <= power_mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_limit_q <= TopState;
      limit_end_q   <= '0;
      last_state_q  <= '0;
      last_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.eval) begin
        if (hit && expired) begin
          level_limit_q <= TopState;
        end
        if (!same) begin
          last_valid_q <= 1'b1;
          last_state_q <= s_cap;
        end
      end
      if (cmd_i.decode && op_q == OpLevel) begin
        if (wl_q < LvlW'(WhitelistLevels)) begin
          level_limit_q <= level_value(wl_q[3:0]);
        end else begin
          level_limit_q <= TopState;
        end
      end
      if (cmd_i.upd && end_sat > limit_end_q) begin
        limit_end_q <= end_sat;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (op_q == OpCool) begin
        kind_o          <= 1'b0;
        status_o        <= 1'b0;
        entry_index_o   <= pick_q;
        big_khz_o       <= pick_opp.big_f;
        little_khz_o    <= pick_opp.lit_f;
        gpu_khz_o       <= pick_opp.gpu_f;
        mem_freq_o      <= pick_opp.mem_f;
        int_freq_out_o  <= int_bus_q;
        disp_freq_out_o <= disp_q;
        cam_freq_out_o  <= cam_q;
        little_cores_o  <= pick_opp.lit_n;
        big_cores_o     <= pick_opp.big_n;
      end else begin
        kind_o          <= 1'b1;
        status_o        <= bad_q;
        entry_index_o   <= '0;
        big_khz_o       <= '0;
        little_khz_o    <= '0;
        gpu_khz_o       <= '0;
        mem_freq_o      <= '0;
        int_freq_out_o  <= '0;
        disp_freq_out_o <= '0;
        cam_freq_out_o  <= '0;
        little_cores_o  <= '0;
        big_cores_o     <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  a_limit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_limit_q <= TopState)
    else $error("level limit beyond top state");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result overwritten while pending");

  a_deadline_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    limit_end_q >= $past(limit_end_q))
    else $error("deadline moved backward");

  a_scan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |=> (pick_q <= idx_q) && (idx_q <= TopState))
    else $error("scan pick ahead of scan index");

endmodule

// ----- sv/thermal_operating_point_limiter_unit.sv -----
`timescale 1ns / 1ps
// A cooling request passes decode and evaluate; in normal mode it then scans
//   the table from the capped state to the top, one ROM entry per cycle, while
//   benchmark mode goes straight to emit. Level writes go from decode to emit;
//   duration writes pass multiply, add and compare. One item at a time: the
//   next beat is accepted once the result register loads or a repeat drops.
// Reset: async active low; clears limit state and restores register defaults.
// ----------------------------------------------------------------------------
// Thermal operating point limiter
// Maps a cooling state, capped by a timed user power level, to an operating
// point from the normal or benchmark table.
// ----------------------------------------------------------------------------
module thermal_operating_point_limiter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    op_i,
  input  logic [tolu_pkg::StW-1:0]      cooling_state_i,
  input  logic [tolu_pkg::LvlW-1:0]     whitelist_level_i,
  input  logic [tolu_pkg::DurW-1:0]     duration_s_i,
  input  logic [tolu_pkg::TimeW-1:0]    now_ms_i,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [tolu_pkg::FreqW-1:0]    cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          kind_o,
  output logic                          status_o,
  output logic [tolu_pkg::StW-1:0]      entry_index_o,
  output logic [tolu_pkg::FreqW-1:0]    big_khz_o,
  output logic [tolu_pkg::FreqW-1:0]    little_khz_o,
  output logic [tolu_pkg::FreqW-1:0]    gpu_khz_o,
  output logic [tolu_pkg::FreqW-1:0]    mem_freq_o,
  output logic [tolu_pkg::FreqW-1:0]    int_freq_out_o,
  output logic [tolu_pkg::FreqW-1:0]    disp_freq_out_o,
  output logic [tolu_pkg::FreqW-1:0]    cam_freq_out_o,
  output logic [tolu_pkg::CoreW-1:0]    little_cores_o,
  output logic [tolu_pkg::CoreW-1:0]    big_cores_o
);
  import tolu_pkg::*;

  tolu_cmd_t cmd;
  tolu_sts_t sts;

  tolu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tolu_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .op_i              (op_i),
    .cooling_state_i   (cooling_state_i),
    .whitelist_level_i (whitelist_level_i),
    .duration_s_i      (duration_s_i),
    .now_ms_i          (now_ms_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .kind_o            (kind_o),
    .status_o          (status_o),
    .entry_index_o     (entry_index_o),
    .big_khz_o         (big_khz_o),
    .little_khz_o      (little_khz_o),
    .gpu_khz_o         (gpu_khz_o),
    .mem_freq_o        (mem_freq_o),
    .int_freq_out_o    (int_freq_out_o),
    .disp_freq_out_o   (disp_freq_out_o),
    .cam_freq_out_o    (cam_freq_out_o),
    .little_cores_o    (little_cores_o),
    .big_cores_o       (big_cores_o)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermal operating point limiter testbench
// Drives cooling requests, power level writes and limit duration writes
// through the valid/ready input, predicts each operating point or status
// beat with its own table copy and cap tracking, and checks every output
// beat in order. The run walks all power modes and frequency register
// extremes under random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import tolu_pkg::*;

  localparam int          RandItems   = 1700;
  localparam int          Segments    = 6;
  localparam int          DrainCycles = 50;
  localparam int          StallLimit  = 4000;
  localparam logic [47:0] TimeMax     = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] OpUnused    = 2'd3;
  localparam logic [1:0] ModeNormalA = 2'd0;
  localparam logic [1:0] ModeNormalB = 2'd1;
  localparam logic [1:0] ModeNormalC = 2'd2;

  localparam logic KindOpp      = 1'b0;
  localparam logic KindStatus   = 1'b1;
  localparam logic StatusOk     = 1'b0;
  localparam logic StatusBadArg = 1'b1;

  // table columns
  localparam int ColLitN = 0;
  localparam int ColBigN = 1;
  localparam int ColBigF = 2;
  localparam int ColLitF = 3;
  localparam int ColGpuF = 4;
  localparam int ColMemF = 5;
  localparam int ColPerf = 6;

  typedef struct {
    logic [1:0]       op;
    logic [StW-1:0]   cstate;
    logic [LvlW-1:0]  level;
    logic [DurW-1:0]  dur_s;
    logic [TimeW-1:0] now;
  } cool_req_t;

  typedef struct {
    logic             kind;
    logic             status;
    logic [StW-1:0]   entry;
    logic [FreqW-1:0] big_f;
    logic [FreqW-1:0] lit_f;
    logic [FreqW-1:0] gpu_f;
    logic [FreqW-1:0] mem_f;
    logic [FreqW-1:0] int_f;
    logic [FreqW-1:0] disp_f;
    logic [FreqW-1:0] cam_f;
    logic [CoreW-1:0] lit_n;
    logic [CoreW-1:0] big_n;
  } opp_result_t;

  class opp_tracker;
    logic [1:0]       pwr_mode;
    logic [FreqW-1:0] int_f, disp_f, cam_f;
    logic [StW-1:0]   level_limit, last_state;
    logic [TimeW-1:0] limit_end;
    bit               last_valid;
    opp_result_t      pending_opps[$];
    int unsigned      nrm_tbl[TableEntries][7];
    // benchmark rows all share lit_f 1500000, gpu 600, mem 825000
    int unsigned      bch_tbl[TableEntries][3];
    logic [StW-1:0]   level_cap[WhitelistLevels];
    int mismatches, n_checked, n_opp, n_status, n_quiet, n_expired;

    function new();
      nrm_tbl = '{
        '{4,4,2000000,1500000,600,825000,37110}, '{4,3,2000000,1500000,600,825000,31110},
        '{4,4,1800000,1500000,600,825000,36360}, '{4,3,1800000,1500000,600,825000,30060},
        '{4,2,2000000,1500000,600,825000,24670}, '{4,4,1600000,1500000,600,825000,33560},
        '{4,2,1800000,1500000,600,825000,23760}, '{4,3,1600000,1500000,600,825000,27960},
        '{4,1,2000000,1500000,600,825000,18160}, '{4,4,1400000,1500000,600,825000,30760},
        '{4,2,1600000,1500000,600,825000,22360}, '{4,3,1400000,1500000,600,825000,25860},
        '{4,4,1200000,1500000,600,825000,27960}, '{4,1,1800000,1500000,600,825000,17460},
        '{4,2,1400000,1500000,600,825000,20960}, '{4,3,1200000,1500000,600,825000,23760},
        '{4,1,1600000,1500000,600,825000,16760}, '{4,4,1000000,1500000,550,825000,25160},
        '{4,2,1200000,1500000,550,825000,19560}, '{4,3,1000000,1500000,550,825000,21660},
        '{4,1,1400000,1500000,550,825000,16760}, '{4,2,1000000,1500000,550,825000,18160},
        '{4,1,1200000,1500000,500,825000,15360}, '{4,1,1000000,1500000,500,825000,14660},
        '{4,1,1000000,1400000,500,825000,14650}, '{4,1,1000000,1200000,500,825000,14645},
        '{3,1,1000000,1400000,500,825000,14644}, '{4,1,1000000,1000000,500,825000,14642},
        '{3,1,1000000,1200000,500,825000,14641}, '{3,1,1000000,1000000,500,825000,14640},
        '{4,0,2000000,1500000,500,633000,11160}, '{4,0,2000000,1500000,420,543000,10460},
        '{4,0,2000000,1400000,420,543000,9672},  '{4,0,2000000,1400000,420,543000,7812},
        '{4,0,2000000,1400000,420,543000,7811}
      };
      bch_tbl = '{
        '{4,4,2000000}, '{4,4,1900000}, '{4,4,1800000}, '{4,4,1700000}, '{4,4,1600000},
        '{4,4,1500000}, '{4,4,1400000}, '{4,4,1300000}, '{4,3,2000000}, '{4,3,1900000},
        '{4,3,1800000}, '{4,3,1700000}, '{4,3,1600000}, '{4,3,1500000}, '{4,3,1400000},
        '{4,3,1300000}, '{4,2,2000000}, '{4,2,1900000}, '{4,2,1800000}, '{4,2,1700000},
        '{4,2,1600000}, '{4,2,1500000}, '{4,2,1400000}, '{4,2,1300000}, '{4,2,1200000},
        '{4,2,1100000}, '{4,1,1800000}, '{4,1,1700000}, '{4,1,1600000}, '{4,1,1500000},
        '{4,1,1400000}, '{4,1,1200000}, '{4,1,1000000}, '{4,1,800000},  '{4,0,2000000}
      };
      // level 0 lifts the cap, the rest cap at fixed states
      level_cap   = '{6'd34, 6'd30, 6'd25, 6'd21, 6'd15, 6'd9, 6'd0};
      pwr_mode    = ModeNormalA;
      int_f       = 21'd543000;
      disp_f      = 21'd317000;
      cam_f       = 21'd777000;
      level_limit = TopState;
      last_state  = '0;
      limit_end   = '0;
      last_valid  = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [FreqW-1:0] val);
      case (idx)
        CfgPowerMode: pwr_mode = val[1:0];
        CfgIntBus:    int_f    = val;
        CfgDisplay:   disp_f   = val;
        CfgCamera:    cam_f    = val;
        default: ;
      endcase
    endfunction

    function void note_request(cool_req_t r);
      opp_result_t    e;
      logic [StW-1:0] s;
      int             pick;
      logic [63:0]    fin;
      e = '{default: '0};
      case (r.op)
        OpCool: begin
          s = (r.cstate > TopState) ? TopState : r.cstate;
          if (s >= level_limit) begin
            if (r.now >= limit_end) begin
              level_limit = TopState;
              n_expired++;
            end else begin
              s = level_limit;
            end
          end
          if (last_valid && s == last_state) begin
            n_quiet++;
            return;
          end
          last_valid = 1'b1;
          last_state = s;
          pick       = s;
          e.kind     = KindOpp;
          e.int_f    = int_f;
          e.disp_f   = disp_f;
          e.cam_f    = cam_f;
          if (pwr_mode == ModeBench) begin
            e.lit_n = CoreW'(bch_tbl[pick][ColLitN]);
            e.big_n = CoreW'(bch_tbl[pick][ColBigN]);
            e.big_f = FreqW'(bch_tbl[pick][ColBigF]);
            e.lit_f = 21'd1500000;
            e.gpu_f = 21'd600;
            e.mem_f = 21'd825000;
          end else begin
            // first entry with the best perf from the capped state down
            for (int j = s; j < TableEntries; j++) begin
              if (nrm_tbl[j][ColPerf] > nrm_tbl[pick][ColPerf]) pick = j;
            end
            e.lit_n = CoreW'(nrm_tbl[pick][ColLitN]);
            e.big_n = CoreW'(nrm_tbl[pick][ColBigN]);
            e.big_f = FreqW'(nrm_tbl[pick][ColBigF]);
            e.lit_f = FreqW'(nrm_tbl[pick][ColLitF]);
            e.gpu_f = FreqW'(nrm_tbl[pick][ColGpuF]);
            e.mem_f = FreqW'(nrm_tbl[pick][ColMemF]);
          end
          e.entry = StW'(pick);
          pending_opps.push_back(e);
        end
        OpLevel: begin
          e.kind = KindStatus;
          if (r.level < WhitelistLevels) begin
            level_limit = level_cap[r.level[2:0]];
            e.status    = StatusOk;
          end else begin
            level_limit = TopState;
            e.status    = StatusBadArg;
          end
          pending_opps.push_back(e);
        end
        OpDuration: begin
          fin = 64'(r.now) + 64'(r.dur_s) * 64'(MsPerSec);
          if (fin > {16'd0, TimeMax}) fin = {16'd0, TimeMax};
          if (fin[47:0] > limit_end) limit_end = fin[47:0];
          e.kind = KindStatus;
          pending_opps.push_back(e);
        end
        default: ;
      endcase
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
    endfunction

    function void cmp(string nm, logic [63:0] x, logic [63:0] a);
      if (a !== x) flag($sformatf("%s expected %0d got %0d", nm, x, a));
    endfunction

    function void check_result(opp_result_t got);
      opp_result_t e;
      if (pending_opps.size() == 0) begin
        flag($sformatf("beat with nothing pending, kind %0d entry %0d", got.kind, got.entry));
        return;
      end
      e = pending_opps.pop_front();
      n_checked++;
      if (e.kind == KindOpp) n_opp++;
      else n_status++;
      cmp("kind", e.kind, got.kind);
      cmp("status", e.status, got.status);
      cmp("entry_index", e.entry, got.entry);
      cmp("big_khz", e.big_f, got.big_f);
      cmp("little_khz", e.lit_f, got.lit_f);
      cmp("gpu_khz", e.gpu_f, got.gpu_f);
      cmp("mem_freq", e.mem_f, got.mem_f);
      cmp("int_freq_out", e.int_f, got.int_f);
      cmp("disp_freq_out", e.disp_f, got.disp_f);
      cmp("cam_freq_out", e.cam_f, got.cam_f);
      cmp("little_cores", e.lit_n, got.lit_n);
      cmp("big_cores", e.big_n, got.big_n);
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         op_i;
  logic [StW-1:0]     cooling_state_i;
  logic [LvlW-1:0]    whitelist_level_i;
  logic [DurW-1:0]    duration_s_i;
  logic [TimeW-1:0]   now_ms_i;
  logic               cfg_we_i;
  logic [1:0]         cfg_index_i;
  logic [FreqW-1:0]   cfg_data_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               kind_o;
  logic               status_o;
  logic [StW-1:0]     entry_index_o;
  logic [FreqW-1:0]   big_khz_o;
  logic [FreqW-1:0]   little_khz_o;
  logic [FreqW-1:0]   gpu_khz_o;
  logic [FreqW-1:0]   mem_freq_o;
  logic [FreqW-1:0]   int_freq_out_o;
  logic [FreqW-1:0]   disp_freq_out_o;
  logic [FreqW-1:0]   cam_freq_out_o;
  logic [CoreW-1:0]   little_cores_o;
  logic [CoreW-1:0]   big_cores_o;

  opp_tracker       sb;
  int               src_idle_pct = 0;
  int               snk_idle_pct = 0;
  int               n_sent = 0;
  int               stall_cycles = 0;
  logic [TimeW-1:0] tnow = '0;

  thermal_operating_point_limiter_unit dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    opp_result_t got;
    if (rst_ni === 1'b1 && out_valid_o && out_ready_i) begin
      got.kind   = kind_o;
      got.status = status_o;
      got.entry  = entry_index_o;
      got.big_f  = big_khz_o;
      got.lit_f  = little_khz_o;
      got.gpu_f  = gpu_khz_o;
      got.mem_f  = mem_freq_o;
      got.int_f  = int_freq_out_o;
      got.disp_f = disp_freq_out_o;
      got.cam_f  = cam_freq_out_o;
      got.lit_n  = little_cores_o;
      got.big_n  = big_cores_o;
      sb.check_result(got);
    end
  end

  // no beat on either side for too long means a hang
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic push_request(cool_req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        = 1'b1;
    op_i              = r.op;
    cooling_state_i   = r.cstate;
    whitelist_level_i = r.level;
    duration_s_i      = r.dur_s;
    now_ms_i          = r.now;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(r);
    if (r.op != OpUnused) n_sent++;
    @(negedge clk_i);
  endtask

  task automatic direct(logic [1:0] op, int cs, int lvl, int dur, logic [TimeW-1:0] now);
    cool_req_t r;
    r.op     = op;
    r.cstate = StW'(cs);
    r.level  = LvlW'(lvl);
    r.dur_s  = DurW'(dur);
    r.now    = now;
    push_request(r);
  endtask

  // all pending beats out, then room for a request that produced nothing
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending_opps.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [FreqW-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_reg(idx, val);
  endtask

  function automatic cool_req_t rand_fields(logic [1:0] op);
    cool_req_t r;
    r.op     = op;
    r.cstate = StW'($urandom_range(63));
    r.level  = LvlW'($urandom);
    r.dur_s  = DurW'($urandom_range(2000000));
    r.now    = tnow;
    return r;
  endfunction

  // states around the current cap hit both the clamp and the deadline check
  function automatic logic [StW-1:0] pick_state();
    int cap;
    cap = sb.level_limit;
    case ($urandom_range(9))
      0, 1:    return StW'(cap);
      2:       return StW'((cap > 0) ? cap - 1 : 0);
      3:       return StW'(cap + 1);
      4:       return StW'($urandom_range(63, 35));
      default: return StW'($urandom_range(34));
    endcase
  endfunction

  function automatic logic [TimeW-1:0] pick_now();
    logic [TimeW-1:0] t;
    case ($urandom_range(19))
      0: t = {16'($urandom), $urandom};
      1: t = sb.limit_end;
      2: t = (sb.limit_end != 0) ? sb.limit_end - 1 : '0;
      3, 4: begin
        if (sb.limit_end > tnow && sb.limit_end < TimeMax - 48'd5000)
          tnow = sb.limit_end + 48'($urandom_range(4000));
        t = tnow;
      end
      default: begin
        tnow = tnow + 48'($urandom_range(3000));
        t    = tnow;
      end
    endcase
    return t;
  endfunction

  function automatic logic [DurW-1:0] pick_duration();
    case ($urandom_range(9))
      0:       return '0;
      1:       return DurW'($urandom_range(2000000));
      default: return DurW'($urandom_range(30));
    endcase
  endfunction

  // level write, maybe a deadline, a burst of cooling requests, maybe one random request
  task automatic random_session();
    cool_req_t r;
    r = rand_fields(OpLevel);
    r.level = ($urandom_range(9) == 0) ? LvlW'($urandom_range(255, WhitelistLevels))
                                       : LvlW'($urandom_range(WhitelistLevels - 1));
    r.now = {16'($urandom), $urandom};
    push_request(r);
    if ($urandom_range(3) != 0) begin
      r = rand_fields(OpDuration);
      r.dur_s = pick_duration();
      push_request(r);
    end
    repeat ($urandom_range(8, 2)) begin
      r = rand_fields(OpCool);
      r.cstate = pick_state();
      r.now    = pick_now();
      push_request(r);
    end
    if ($urandom_range(4) == 0) begin
      r = rand_fields(2'($urandom_range(3)));
      if (r.op != OpDuration) r.now = {16'($urandom), $urandom};
      push_request(r);
    end
  endtask

  task automatic apply_settings(int seg);
    logic [1:0]       modes[Segments];
    logic [FreqW-1:0] fv[3];
    modes = '{ModeNormalA, ModeBench, ModeNormalB, ModeBench, ModeNormalC, ModeNormalA};
    for (int k = 0; k < 3; k++) begin
      fv[k] = (seg == 0) ? '0 : (seg == 1) ? 21'd2000000 : FreqW'($urandom_range(2000000));
    end
    write_reg(CfgPowerMode, {19'($urandom), modes[seg]});
    write_reg(CfgIntBus, fv[0]);
    write_reg(CfgDisplay, fv[1]);
    write_reg(CfgCamera, fv[2]);
    src_idle_pct = (seg < 2) ? 12 : (seg < 4) ? 72 : 0;
    snk_idle_pct = (seg < 2) ? 72 : (seg < 4) ? 12 : 0;
  endtask

  initial begin
    int target;
    bit failed;
    sb                = new();
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    op_i              = OpCool;
    cooling_state_i   = '0;
    whitelist_level_i = '0;
    duration_s_i      = '0;
    now_ms_i          = '0;
    cfg_we_i          = 1'b0;
    cfg_index_i       = CfgPowerMode;
    cfg_data_i        = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset register values
    direct(OpCool, 0, 0, 0, 0);             // first request always sent
    direct(OpCool, 0, 0, 0, 0);             // repeat held back
    direct(OpCool, 63, 0, 0, 0);            // saturates, deadline already met
    direct(OpCool, 35, 0, 0, 0);
    direct(OpLevel, 0, 5, 0, 0);
    direct(OpDuration, 0, 0, 10, 1000);
    direct(OpCool, 20, 0, 0, 2000);         // capped to the level value
    direct(OpCool, 9, 0, 0, 10999);
    direct(OpCool, 3, 0, 0, 3000);          // below the cap
    direct(OpCool, 30, 0, 0, 11000);        // deadline just reached
    direct(OpLevel, 0, WhitelistLevels, 0, 0);
    direct(OpLevel, 0, 255, 0, 0);
    direct(OpLevel, 0, 6, 0, 0);
    direct(OpDuration, 0, 0, 0, 500);       // earlier deadline does not shrink it
    direct(OpCool, 0, 0, 0, 5000);
    direct(OpUnused, 63, 255, 2000000, TimeMax);
    direct(OpLevel, 0, 1, 0, 0);
    direct(OpDuration, 0, 0, 2000000, 12000);
    direct(OpCool, 40, 0, 0, 13000);
    direct(OpLevel, 0, 3, 0, 0);
    direct(OpCool, 34, 0, 0, 15000);
    direct(OpLevel, 0, 4, 0, 0);
    direct(OpCool, 50, 0, 0, TimeMax);
    drain();
    write_reg(CfgPowerMode, ModeBench);
    write_reg(CfgIntBus, '0);
    write_reg(CfgDisplay, 21'd2000000);
    write_reg(CfgCamera, 21'd1);
    direct(OpCool, 0, 0, 0, 16000);
    direct(OpCool, 34, 0, 0, 17000);
    direct(OpCool, 17, 0, 0, 18000);
    tnow = sb.limit_end + 48'd1;

    for (int seg = 0; seg < Segments; seg++) begin
      drain();
      apply_settings(seg);
      target = n_sent + RandItems / Segments;
      while (n_sent < target) random_session();
    end

    // deadline sum saturating at the top of the time range
    direct(OpDuration, 0, 0, 2000000, TimeMax - 48'd5);
    direct(OpCool, 34, 0, 0, TimeMax - 48'd1);
    direct(OpCool, 20, 0, 0, TimeMax);
    direct(OpCool, 34, 0, 0, TimeMax);
    drain();

    failed = (sb.mismatches != 0) || (sb.pending_opps.size() != 0);
    $display("run covered %0d requests and %0d checked beats: %0d operating points, %0d status",
             n_sent, sb.n_checked, sb.n_opp, sb.n_status);
    $display("  %0d repeats held back, %0d limit expiries, %0d mismatches",
             sb.n_quiet, sb.n_expired, sb.mismatches);
    if (!failed) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
